[rtl/isrc_pkg.sv]
// Shared types, constants and the one's-complement adder for the IPv4 source
// rewrite checksum block. No dependencies.
package isrc_pkg;

   // Reset value of the source address register: 127.1.0.2.
   localparam logic [31:0] SOURCE_RESET = 32'h7F01_0002;
   localparam logic [15:0] TCP_PROTOCOL = 16'd6;

   // Header length field values below this are malformed.
   localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

   // Byte offsets of the words that the sums treat specially.
   localparam int unsigned IP_CHECKSUM_OFFSET = 10;
   localparam int unsigned SRC_HIGH_OFFSET    = 12;
   localparam int unsigned SRC_LOW_OFFSET     = 14;
   localparam int unsigned DST_HIGH_OFFSET    = 16;
   localparam int unsigned DST_LOW_OFFSET     = 18;
   localparam int unsigned TCP_CHECKSUM_OFFSET = 16;

   // Everything the finishing stage needs from one completed packet.
   typedef struct packed {
      logic [15:0] header_sum;
      logic [15:0] segment_sum;
      logic [15:0] segment_bytes;
      logic [5:0]  header_bytes;
      logic        malformed;
   } sums_type;

   // 16-bit one's-complement add with the end-around carry folded in.
   function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
      logic [16:0] t;
      t = {1'b0, s} + {1'b0, w};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

[rtl/isrc_accum.sv]
// Running header and segment sums over the packet bytes, one byte a cycle unless a last byte waits on the results.
// Depends on isrc_pkg; hands a sums_type record to the finishing stage.
module isrc_accum #(
   parameter int unsigned MAX_PACKET_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  logic [31:0]        src_addr,
   input  logic               res_ready,
   output logic               in_take,
   output logic               sums_valid,
   output isrc_pkg::sums_type sums
);
   import isrc_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       words_ff, words_in;
   logic [7:0]       held_ff, held_in;
   logic [15:0]      hsum_ff, hsum_in;
   logic [15:0]      ssum_ff, ssum_in;
   logic             sums_valid_ff, sums_valid_in;
   sums_type         sums_ff, sums_in;

   logic             in_range;
   logic             sums_ready;
   logic [POS_W-1:0] pos_next;
   logic [3:0]       words_cur;
   logic [7:0]       held_cur;
   logic [5:0]       hdr;
   logic [POS_W-1:0] hdr_pos;
   logic [POS_W-1:0] word_pos;
   logic             word_full;
   logic             word_pad;
   logic [15:0]      word;
   logic [15:0]      hword;
   logic [15:0]      sword;
   logic             in_header;
   logic             seg_add;
   logic [15:0]      hsum_upd;
   logic [15:0]      ssum_upd;
   logic [POS_W-1:0] seg_full;

   assign sums_ready = !sums_valid_ff || res_ready;
   assign in_take    = in_valid && (!in_last || sums_ready);

   always_comb begin
      in_range  = pos_ff < MAX_POS;
      pos_next  = in_range ? pos_ff + POS_W'(1) : pos_ff;
      words_cur = (in_range && pos_ff == '0) ? in_byte[3:0] : words_ff;
      held_cur  = (in_range && !pos_ff[0]) ? in_byte : held_ff;
      hdr       = {words_cur, 2'b00};
      hdr_pos   = POS_W'(hdr);

      // A full word completes on an odd byte; an odd final byte is padded low.
      word_full = in_range && pos_ff[0];
      word_pad  = in_last && pos_next[0];
      word_pos  = {pos_ff[POS_W-1:1], 1'b0};
      word      = word_full ? {held_ff, in_byte} : {held_cur, 8'h00};

      in_header = word_pos < hdr_pos;
      if (word_pos == POS_W'(IP_CHECKSUM_OFFSET)) begin
         hword = '0;
      end else if (word_pos == POS_W'(SRC_HIGH_OFFSET)) begin
         hword = src_addr[31:16];
      end else if (word_pos == POS_W'(SRC_LOW_OFFSET)) begin
         hword = src_addr[15:0];
      end else begin
         hword = word;
      end
      // The destination address also goes into the pseudo header.
      seg_add = in_header ? (word_pos == POS_W'(DST_HIGH_OFFSET) ||
                             word_pos == POS_W'(DST_LOW_OFFSET)) : 1'b1;
      sword   = (word_pos == hdr_pos + POS_W'(TCP_CHECKSUM_OFFSET)) ? 16'd0 : word;

      hsum_upd = hsum_ff;
      ssum_upd = ssum_ff;
      if (word_full || word_pad) begin
         if (in_header) begin
            hsum_upd = oc_add(hsum_ff, hword);
         end
         if (seg_add) begin
            ssum_upd = oc_add(ssum_ff, sword);
         end
      end

      seg_full = pos_next - hdr_pos;
      sums_in.header_sum    = hsum_upd;
      sums_in.segment_sum   = ssum_upd;
      sums_in.segment_bytes = 16'(seg_full);
      sums_in.header_bytes  = hdr;
      sums_in.malformed     = (words_cur < MIN_HEADER_WORDS) || (pos_next < hdr_pos);
   end

   always_comb begin
      pos_in   = pos_ff;
      words_in = words_ff;
      held_in  = held_ff;
      hsum_in  = hsum_ff;
      ssum_in  = ssum_ff;
      if (in_take) begin
         if (in_last) begin
            pos_in   = '0;
            words_in = '0;
            held_in  = '0;
            hsum_in  = '0;
            ssum_in  = '0;
         end else begin
            pos_in   = pos_next;
            words_in = words_cur;
            held_in  = held_cur;
            hsum_in  = hsum_upd;
            ssum_in  = ssum_upd;
         end
      end
      sums_valid_in = sums_ready ? (in_take && in_last) : sums_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         words_ff      <= '0;
         held_ff       <= '0;
         hsum_ff       <= '0;
         ssum_ff       <= '0;
         sums_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         words_ff      <= words_in;
         held_ff       <= held_in;
         hsum_ff       <= hsum_in;
         ssum_ff       <= ssum_in;
         sums_valid_ff <= sums_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_last) begin
         sums_ff <= sums_in;
      end
   end

   assign sums_valid = sums_valid_ff;
   assign sums       = sums_ff;

`ifndef SYNTH
   // The last byte of a packet leaves the running state cleared for the next.
   assert property (@(posedge clock) disable iff (reset)
      in_take && in_last |=> pos_ff == '0 && hsum_ff == '0 && ssum_ff == '0)
      else $error("accumulator state not cleared after the last byte");
`endif

endmodule

[rtl/isrc_finish.sv]
// Adds the TCP pseudo header, complements both sums (zeroes them for a malformed packet) and holds the result.
// Depends on isrc_pkg; fed by isrc_accum.
module isrc_finish (
   input  logic               clock,
   input  logic               reset,
   input  logic               sums_valid,
   input  isrc_pkg::sums_type sums,
   input  logic [31:0]        src_addr,
   output logic               res_ready,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [15:0]        rsp_ip_header_checksum,
   output logic [15:0]        rsp_tcp_segment_checksum,
   output logic [5:0]         rsp_header_bytes,
   output logic [15:0]        rsp_segment_bytes,
   output logic               rsp_malformed
);
   import isrc_pkg::*;

   logic        valid_ff, valid_in;
   logic [15:0] ip_sum_ff, ip_sum_in;
   logic [15:0] tcp_sum_ff, tcp_sum_in;
   logic [5:0]  hdr_ff;
   logic [15:0] seg_ff, seg_in;
   logic        bad_ff;

   logic [18:0] wide;
   logic [16:0] fold1;
   logic [15:0] fold2;

   assign res_ready = !valid_ff || !rsp_stall;

   // A single wide sum folded twice equals the chain of end-around adds.
   always_comb begin
      wide = {3'd0, sums.segment_sum} + {3'd0, src_addr[31:16]}
           + {3'd0, src_addr[15:0]} + {3'd0, TCP_PROTOCOL}
           + {3'd0, sums.segment_bytes};
      fold1 = {1'b0, wide[15:0]} + {14'd0, wide[18:16]};
      fold2 = fold1[15:0] + {15'd0, fold1[16]};

      ip_sum_in  = sums.malformed ? 16'd0 : ~sums.header_sum;
      tcp_sum_in = sums.malformed ? 16'd0 : ~fold2;
      seg_in     = sums.malformed ? 16'd0 : sums.segment_bytes;
      valid_in   = res_ready ? sums_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && sums_valid) begin
         ip_sum_ff  <= ip_sum_in;
         tcp_sum_ff <= tcp_sum_in;
         hdr_ff     <= sums.header_bytes;
         seg_ff     <= seg_in;
         bad_ff     <= sums.malformed;
      end
   end

   assign rsp_valid                = valid_ff;
   assign rsp_ip_header_checksum   = ip_sum_ff;
   assign rsp_tcp_segment_checksum = tcp_sum_ff;
   assign rsp_header_bytes         = hdr_ff;
   assign rsp_segment_bytes        = seg_ff;
   assign rsp_malformed            = bad_ff;

endmodule

[rtl/ipv4_source_rewrite_checksum.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  packet byte, last-byte marker
// rsp       out        rsp_valid/rsp_stall  both checksums, lengths, malformed flag
// csr       in         csr_wr_en            new source address
//
// One byte is accepted every cycle unless the input stalls; the running
// one's-complement adds in the accumulator set that rate. A last byte's
// result passes the input, sums and finish registers. Reset is synchronous
// and returns the source address to 127.1.0.2. The input stalls only when
// a last byte must wait behind two undelivered results.
//
// Top level of the IPv4 source rewrite checksum block.
// Depends on isrc_pkg, isrc_accum and isrc_finish.
module ipv4_source_rewrite_checksum #(
   parameter int unsigned MAX_PACKET_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_ip_header_checksum,
   output logic [15:0] rsp_tcp_segment_checksum,
   output logic [5:0]  rsp_header_bytes,
   output logic [15:0] rsp_segment_bytes,
   output logic        rsp_malformed,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import isrc_pkg::*;

   logic [31:0] source_ff, source_in;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        in_take;
   logic        res_ready;
   logic        sums_valid;
   sums_type    sums;

   assign source_in   = csr_wr_en ? csr_wr_data : source_ff;
   assign req_stall   = in_valid_ff && !in_take;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff   <= SOURCE_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         source_ff   <= source_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_packet_byte;
         in_last_ff <= req_last_byte;
      end
   end

   isrc_accum #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .src_addr  (source_ff),
      .res_ready (res_ready),
      .in_take   (in_take),
      .sums_valid(sums_valid),
      .sums      (sums)
   );

   isrc_finish u_finish (
      .clock                   (clock),
      .reset                   (reset),
      .sums_valid              (sums_valid),
      .sums                    (sums),
      .src_addr                (source_ff),
      .res_ready               (res_ready),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_ip_header_checksum  (rsp_ip_header_checksum),
      .rsp_tcp_segment_checksum(rsp_tcp_segment_checksum),
      .rsp_header_bytes        (rsp_header_bytes),
      .rsp_segment_bytes       (rsp_segment_bytes),
      .rsp_malformed           (rsp_malformed)
   );

`ifndef SYNTH
   // Only a waiting last byte can hold up the request side.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_last_ff && sums_valid)
      else $error("request stalled without a blocked last byte");

   // A malformed packet gives zero checksums and a zero segment length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_ip_header_checksum == 16'd0 &&
         rsp_tcp_segment_checksum == 16'd0 && rsp_segment_bytes == 16'd0)
      else $error("malformed result carries non-zero fields");

   // A well-formed packet has a header of at least twenty bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_malformed |-> rsp_header_bytes >= 6'd20)
      else $error("well-formed result with short header");
`endif

endmodule
